// ===== sv/sam_pkg.sv =====
// Shared types and constants for the sprite attribute memory port.
package sam_pkg;

   localparam int DATA_W = 8;
   localparam int ATTR_DEPTH = 160;
   localparam int SPARE_DEPTH = 48;
   localparam int ATTR_AW = $clog2(ATTR_DEPTH);
   localparam int SPARE_AW = $clog2(SPARE_DEPTH);

   localparam logic [7:0] TAIL_SECOND = 8'hC0;
   localparam logic [7:0] TAIL_THIRD = 8'hE0;
   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

   typedef enum logic [1:0] {
      CMD_CPU_READ = 2'd0,
      CMD_CPU_WRITE = 2'd1,
      CMD_PPU_READ = 2'd2,
      CMD_PPU_WRITE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_MONO = 2'd0,
      KIND_COLOR_D = 2'd1,
      KIND_COLOR_EARLY = 2'd2,
      KIND_COLOR_LATE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      SEL_ZERO = 3'd0,
      SEL_ONES = 3'd1,
      SEL_ATTR = 3'd2,
      SEL_SPARE = 3'd3,
      SEL_NIBBLE = 3'd4
   } select_type;

   typedef struct packed {
      logic attr_we;
      logic [ATTR_AW-1:0] attr_addr;
      logic spare_we;
      logic [SPARE_AW-1:0] spare_addr;
      select_type sel;
   } access_type;

endpackage

// ===== sv/sprite_attribute_memory_port.sv =====
// Sprite attribute memory port: shared cpu/ppu window with revision-dependent tail.
// Result path: store read at accept, result register loaded when stage 1 advances.
// Throughput: one item per cycle unless stalled; stores read and write at accept.
// Reset: console kind returns to zero, all store valid bits clear so every byte
// reads as zero, and both pipeline stages empty; no clearing pass is needed.
module sprite_attribute_memory_port (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_address,
   input  logic [7:0] req_write_data,
   input  logic       req_cpu_access_open,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);
   import sam_pkg::*;

   kind_type          kind_ff;
   access_type        access;
   logic              accept;
   logic              s1_advance;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   select_type        s1_sel_ff;
   logic [3:0]        s1_nibble_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [7:0]        rsp_data_ff;
   logic [7:0]        rsp_data_in;
   logic [DATA_W-1:0] attr_rd;
   logic [DATA_W-1:0] spare_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_MONO;
      end else if (csr_write_enable) begin
         kind_ff <= kind_type'(csr_write_data);
      end
   end

   sam_decode u_decode (
      .command         (command_type'(req_command)),
      .address         (req_address),
      .cpu_access_open (req_cpu_access_open),
      .console_kind    (kind_ff),
      .access          (access)
   );

   sam_store #(.DEPTH(ATTR_DEPTH)) u_attr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && access.attr_we),
      .wr_addr (access.attr_addr),
      .wr_data (req_write_data),
      .rd_en   (accept),
      .rd_addr (access.attr_addr),
      .rd_data (attr_rd)
   );

   sam_store #(.DEPTH(SPARE_DEPTH)) u_spare (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && access.spare_we),
      .wr_addr (access.spare_addr),
      .wr_data (req_write_data),
      .rd_en   (accept),
      .rd_addr (access.spare_addr),
      .rd_data (spare_rd)
   );

   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_valid_in = accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      case (s1_sel_ff)
         SEL_ONES: rsp_data_in = BYTE_ONES;
         SEL_ATTR: rsp_data_in = attr_rd;
         SEL_SPARE: rsp_data_in = spare_rd;
         SEL_NIBBLE: rsp_data_in = {s1_nibble_ff, s1_nibble_ff};
         default: rsp_data_in = BYTE_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sel_ff <= access.sel;
         s1_nibble_ff <= req_address[7:4];
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ===== sv/sam_store.sv =====
// Byte store with per-entry valid bits; unwritten entries read as zero.
module sam_store #(
   parameter int DEPTH = 160
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [sam_pkg::DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [sam_pkg::DATA_W-1:0] rd_data
);
   import sam_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : BYTE_ZERO;

endmodule

// ===== sv/sam_decode.sv =====
// Access decode: ownership, store selection, tail mapping and result source.
module sam_decode (
   input  sam_pkg::command_type command,
   input  logic [7:0]           address,
   input  logic                 cpu_access_open,
   input  sam_pkg::kind_type    console_kind,
   output sam_pkg::access_type  access
);
   import sam_pkg::*;

   logic                in_attr;
   logic                cpu_cmd;
   logic                is_write;
   logic                granted;
   logic                spare_hit;
   logic [SPARE_AW-1:0] spare_idx;

   assign in_attr = address < ATTR_AW'(ATTR_DEPTH);
   assign cpu_cmd = (command == CMD_CPU_READ) || (command == CMD_CPU_WRITE);
   assign is_write = (command == CMD_CPU_WRITE) || (command == CMD_PPU_WRITE);
   assign granted = cpu_cmd ? cpu_access_open : !cpu_access_open;

   always_comb begin
      spare_hit = 1'b0;
      spare_idx = '0;
      unique case (console_kind)
         KIND_COLOR_D: begin
            spare_hit = 1'b1;
            if (address < TAIL_SECOND) begin
               spare_idx = {1'b0, address[4:0]};
            end else begin
               spare_idx = {2'b10, address[3:0]};
            end
         end
         KIND_COLOR_EARLY: begin
            spare_hit = 1'b1;
            if (address < TAIL_SECOND) begin
               spare_idx = {3'b000, address[2:0]};
            end else if (address < TAIL_THIRD) begin
               spare_idx = {3'b001, address[2:0]};
            end else begin
               spare_idx = {3'b010, address[2:0]};
            end
         end
         KIND_MONO, KIND_COLOR_LATE: begin
            spare_hit = 1'b0;
         end
         default: begin
            spare_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      access.attr_we = granted && is_write && in_attr;
      access.attr_addr = in_attr ? address : '0;
      access.spare_we = cpu_cmd && granted && is_write && !in_attr && spare_hit;
      access.spare_addr = spare_idx;
      if (is_write) begin
         access.sel = SEL_ZERO;
      end else if (!granted) begin
         access.sel = SEL_ONES;
      end else if (in_attr) begin
         access.sel = SEL_ATTR;
      end else if (!cpu_cmd) begin
         access.sel = SEL_ZERO;
      end else if (console_kind == KIND_COLOR_LATE) begin
         access.sel = SEL_NIBBLE;
      end else if (spare_hit) begin
         access.sel = SEL_SPARE;
      end else begin
         access.sel = SEL_ZERO;
      end
   end

endmodule
